@@ rtl/normalized_magnitude_entropy_assert.svh @@
// assertion macros used by the checker file
`ifndef NORMALIZED_MAGNITUDE_ENTROPY_ASSERT_SVH
`define NORMALIZED_MAGNITUDE_ENTROPY_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define NME_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define NME_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nme_pkg.sv @@
`default_nettype none
package nme_pkg;

  localparam int MaxSamples = 4096;
  localparam int SampleBits = 16;
  localparam int PartW      = (SampleBits < 16) ? SampleBits : 16;
  localparam int CntW       = $clog2(MaxSamples + 2);

  localparam int QW     = 44;
  localparam int AW     = 30;
  localparam int BW     = 56;
  localparam int RadW   = 54;
  localparam int RootW  = 27;
  localparam int NumW   = 59;
  localparam int DvdW   = 60;
  localparam int MantW  = 31;
  localparam int FracW  = 24;
  localparam int LogW   = 30;
  localparam int ItrW   = 6;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic [5:0]  TopBit = 6'd43;

  typedef struct packed {
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic [23:0] entropy_value;
    logic        zero_norm_error;
    logic        length_error;
  } result_t;

  typedef struct packed {
    logic [PartW-1:0] mag_re;
    logic [PartW-1:0] mag_im;
    logic             do_sum;
    logic             last;
    logic             len_err;
  } elem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    BkIdle, BkSq0, BkSq1, BkSq2, BkRoot, BkNorm, BkSqr, BkSqrR,
    BkLn, BkLnR, BkAl, BkAlR, BkLast, BkPs, BkPsR, BkDiv
  } back_state_e;

  // absolute value of the low PartW bits read as two's complement
  function automatic logic [PartW-1:0] part_abs(input logic [15:0] f);
    logic [PartW-1:0] v;
    v = f[PartW-1:0];
    if (v[PartW-1]) begin
      return PartW'(-v);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/nme_front.sv @@
`default_nettype none
module nme_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire nme_pkg::sample_t sample_i,
  output nme_pkg::elem_t        elem_o
);

  logic [nme_pkg::CntW-1:0] cnt_q, cnt_d, cnt_inc;
  localparam logic [nme_pkg::CntW-1:0] Max = nme_pkg::CntW'(nme_pkg::MaxSamples);

  always_comb begin
    // count saturates one past the limit
    cnt_inc = (cnt_q <= Max) ? cnt_q + 1'b1 : cnt_q;
    elem_o.mag_re  = nme_pkg::part_abs(sample_i.sample_real);
    elem_o.mag_im  = nme_pkg::part_abs(sample_i.sample_imag);
    elem_o.do_sum  = (cnt_q < Max);
    elem_o.last    = sample_i.last_sample;
    elem_o.len_err = (cnt_inc > Max);
    cnt_d = cnt_q;
    if (accept_i) begin
      cnt_d = sample_i.last_sample ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nme_fifo.sv @@
`default_nettype none
module nme_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire nme_pkg::elem_t  data_i,
  input  wire logic            pop_i,
  output nme_pkg::elem_t       data_o,
  output nme_pkg::fifo_stat_t  stat_o
);

  nme_pkg::elem_t mem_q [nme_pkg::FifoDepth];
  logic [nme_pkg::FifoAw-1:0] wr_q, rd_q;
  logic [nme_pkg::FifoAw:0]   cnt_q;

  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (nme_pkg::FifoAw+1)'(nme_pkg::FifoDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/nme_back.sv @@
`default_nettype none
module nme_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire nme_pkg::elem_t      elem_i,
  input  wire nme_pkg::fifo_stat_t stat_i,
  output logic                     pop_o,
  output nme_pkg::result_t         result_o,
  output logic                     result_valid_o
);

  localparam int RootW = nme_pkg::RootW;
  localparam int DvdW  = nme_pkg::DvdW;

  nme_pkg::back_state_e state_q, state_d;

  nme_pkg::elem_t                elem_q;
  logic [31:0]                   mul_a, mul_b;
  logic [63:0]                   prod_q;
  logic [31:0]                   tmp_q, sq;
  logic [nme_pkg::QW-1:0]        sos_q;
  logic [nme_pkg::AW-1:0]        soa_q;
  logic [nme_pkg::BW-1:0]        sml_q;
  logic [nme_pkg::RadW-1:0]      rad_q;
  logic [RootW-1:0]              root_q, root_n;
  logic [RootW+1:0]              rem_q, rem_new;
  logic [RootW+3:0]              rem_n, trial;
  logic [nme_pkg::ItrW-1:0]      itr_q;
  logic                          final_q;
  logic [15:0]                   a_q;
  logic [nme_pkg::QW-1:0]        lg_q;
  logic [5:0]                    e_q;
  logic [nme_pkg::MantW-1:0]     mant_q;
  logic [nme_pkg::FracW-1:0]     frac_q;
  logic [31:0]                   sqv;
  logic [nme_pkg::LogW-1:0]      ln_q;
  logic [28:0]                   lns_q;
  logic [nme_pkg::NumW-1:0]      num_q, pos;
  logic [RootW-1:0]              s5_q, drem_q, drem_new;
  logic [RootW:0]                drem_n;
  logic                          qbit;
  logic [DvdW-1:0]               dvd_q, quo;
  logic [23:0]                   psi;
  logic                          itr_end;
  nme_pkg::result_t              res_q;
  logic                          valid_q;

  assign result_o       = res_q;
  assign result_valid_o = valid_q;

  always_comb begin
    sq      = tmp_q + prod_q[31:0];
    itr_end = (itr_q == nme_pkg::ItrW'(1));
    sqv     = prod_q[61:30];
    pos     = prod_q[nme_pkg::NumW-1:0];
    // one digit pair of the square root
    rem_n   = {rem_q, rad_q[nme_pkg::RadW-1 -: 2]};
    trial   = (RootW+4)'({root_q, 2'b01});
    if (rem_n >= trial) begin
      rem_new = (RootW+2)'(rem_n - trial);
      root_n  = {root_q[RootW-2:0], 1'b1};
    end else begin
      rem_new = rem_n[RootW+1:0];
      root_n  = {root_q[RootW-2:0], 1'b0};
    end
    // one quotient bit of the divide
    drem_n = {drem_q, dvd_q[DvdW-1]};
    qbit   = (drem_n >= {1'b0, s5_q});
    drem_new = qbit ? RootW'(drem_n - {1'b0, s5_q}) : drem_n[RootW-1:0];
    quo    = {dvd_q[DvdW-2:0], qbit};
    psi    = (quo > DvdW'(24'hFFFFFF)) ? 24'hFFFFFF : quo[23:0];
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      nme_pkg::BkIdle: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = elem_i.do_sum ? nme_pkg::BkSq0 : nme_pkg::BkLast;
        end
      end
      nme_pkg::BkSq0: begin
        mul_a   = 32'(elem_q.mag_re);
        mul_b   = 32'(elem_q.mag_re);
        state_d = nme_pkg::BkSq1;
      end
      nme_pkg::BkSq1: begin
        mul_a   = 32'(elem_q.mag_im);
        mul_b   = 32'(elem_q.mag_im);
        state_d = nme_pkg::BkSq2;
      end
      nme_pkg::BkSq2: begin
        state_d = (sq == '0) ? nme_pkg::BkLast : nme_pkg::BkRoot;
      end
      nme_pkg::BkRoot: begin
        if (itr_end) begin
          state_d = final_q ? nme_pkg::BkDiv : nme_pkg::BkNorm;
        end
      end
      nme_pkg::BkNorm: begin
        if (lg_q[nme_pkg::QW-1]) begin
          state_d = nme_pkg::BkSqr;
        end
      end
      nme_pkg::BkSqr: begin
        mul_a   = 32'(mant_q);
        mul_b   = 32'(mant_q);
        state_d = nme_pkg::BkSqrR;
      end
      nme_pkg::BkSqrR: begin
        state_d = itr_end ? nme_pkg::BkLn : nme_pkg::BkSqr;
      end
      nme_pkg::BkLn: begin
        mul_a   = 32'({e_q, frac_q});
        mul_b   = nme_pkg::Ln2Q32;
        state_d = nme_pkg::BkLnR;
      end
      nme_pkg::BkLnR: begin
        state_d = final_q ? nme_pkg::BkPs : nme_pkg::BkAl;
      end
      nme_pkg::BkAl: begin
        mul_a   = 32'(a_q);
        mul_b   = 32'(ln_q);
        state_d = nme_pkg::BkAlR;
      end
      nme_pkg::BkAlR: begin
        state_d = nme_pkg::BkLast;
      end
      nme_pkg::BkLast: begin
        if (!elem_q.last || elem_q.len_err || (sos_q == '0)) begin
          state_d = nme_pkg::BkIdle;
        end else begin
          state_d = nme_pkg::BkNorm;
        end
      end
      nme_pkg::BkPs: begin
        mul_a   = 32'(lns_q);
        mul_b   = 32'(soa_q);
        state_d = nme_pkg::BkPsR;
      end
      nme_pkg::BkPsR: begin
        state_d = nme_pkg::BkRoot;
      end
      nme_pkg::BkDiv: begin
        if (itr_end) begin
          state_d = nme_pkg::BkIdle;
        end
      end
      default: begin
        state_d = nme_pkg::BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nme_pkg::BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      nme_pkg::BkIdle: begin
        if (!stat_i.empty) begin
          elem_q <= elem_i;
        end
      end
      nme_pkg::BkSq1: begin
        tmp_q <= prod_q[31:0];
      end
      nme_pkg::BkSq2: begin
        rad_q   <= nme_pkg::RadW'(sq);
        root_q  <= '0;
        rem_q   <= '0;
        itr_q   <= nme_pkg::ItrW'(RootW);
        final_q <= 1'b0;
      end
      nme_pkg::BkRoot: begin
        rad_q  <= rad_q << 2;
        rem_q  <= rem_new;
        root_q <= root_n;
        itr_q  <= itr_q - 1'b1;
        if (itr_end) begin
          if (!final_q) begin
            a_q  <= root_n[15:0];
            lg_q <= nme_pkg::QW'(root_n[15:0]);
            e_q  <= nme_pkg::TopBit;
          end else begin
            s5_q   <= root_n;
            dvd_q  <= {num_q, 1'b0};
            drem_q <= '0;
            itr_q  <= nme_pkg::ItrW'(DvdW);
          end
        end
      end
      nme_pkg::BkNorm: begin
        if (!lg_q[nme_pkg::QW-1]) begin
          lg_q <= lg_q << 1;
          e_q  <= e_q - 1'b1;
        end else begin
          mant_q <= lg_q[nme_pkg::QW-1 -: nme_pkg::MantW];
          frac_q <= '0;
          itr_q  <= nme_pkg::ItrW'(nme_pkg::FracW);
        end
      end
      nme_pkg::BkSqrR: begin
        frac_q <= {frac_q[nme_pkg::FracW-2:0], sqv[31]};
        mant_q <= sqv[31] ? sqv[31:1] : sqv[30:0];
        itr_q  <= itr_q - 1'b1;
      end
      nme_pkg::BkLnR: begin
        ln_q  <= prod_q[61:32];
        lns_q <= prod_q[61:33];
      end
      nme_pkg::BkLast: begin
        final_q <= 1'b1;
        lg_q    <= sos_q;
        e_q     <= nme_pkg::TopBit;
      end
      nme_pkg::BkPsR: begin
        num_q  <= (pos > nme_pkg::NumW'(sml_q)) ? pos - nme_pkg::NumW'(sml_q) : '0;
        rad_q  <= {sos_q, 10'b0};
        root_q <= '0;
        rem_q  <= '0;
        itr_q  <= nme_pkg::ItrW'(RootW);
      end
      nme_pkg::BkDiv: begin
        drem_q <= drem_new;
        dvd_q  <= quo;
        itr_q  <= itr_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // running sums and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sos_q   <= '0;
      soa_q   <= '0;
      sml_q   <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        nme_pkg::BkSq2: begin
          sos_q <= sos_q + nme_pkg::QW'(sq);
        end
        nme_pkg::BkRoot: begin
          if (itr_end && !final_q) begin
            soa_q <= soa_q + nme_pkg::AW'(root_n[15:0]);
          end
        end
        nme_pkg::BkAlR: begin
          sml_q <= sml_q + nme_pkg::BW'(prod_q[45:0]);
        end
        nme_pkg::BkLast: begin
          if (elem_q.last && (elem_q.len_err || (sos_q == '0))) begin
            valid_q               <= 1'b1;
            res_q.entropy_value   <= '0;
            res_q.length_error    <= elem_q.len_err;
            res_q.zero_norm_error <= !elem_q.len_err;
            sos_q <= '0;
            soa_q <= '0;
            sml_q <= '0;
          end
        end
        nme_pkg::BkDiv: begin
          if (itr_end) begin
            valid_q               <= 1'b1;
            res_q.entropy_value   <= psi;
            res_q.length_error    <= 1'b0;
            res_q.zero_norm_error <= 1'b0;
            sos_q <= '0;
            soa_q <= '0;
            sml_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/normalized_magnitude_entropy.sv @@
`default_nettype none
// Entropy focus metric of a complex vector: one sample per request, the last one
// marked; one result (psi in unsigned Q4.20 plus two error flags) is strobed for
// a single cycle once the last sample is done, with no hold-off by the receiver.
// Requests go into a four-entry queue, so at least five samples are taken back to
// back while busy is low when the back end starts idle. The back end works one
// sample at a time with one shared 32x32 multiplier: a nonzero sample takes 27
// square-root steps, one normalize shift per cycle and 24 squarings. The last
// sample of a valid vector adds the log of the sum of squares, two multiplies,
// a 27-step square root and a 60-step divide before the result strobe. Throughput
// is set by that iterative back end; busy is high while the queue is full.
module normalized_magnitude_entropy (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire nme_pkg::sample_t sample_i,
  output nme_pkg::result_t      result_o,
  output logic                  result_valid_o
);

  nme_pkg::elem_t      front_elem, head_elem;
  nme_pkg::fifo_stat_t stat;
  logic                accept, pop;

  assign busy   = stat.full;
  assign accept = start && !stat.full;

  nme_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sample_i (sample_i),
    .elem_o   (front_elem)
  );

  nme_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (front_elem),
    .pop_i  (pop),
    .data_o (head_elem),
    .stat_o (stat)
  );

  nme_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .elem_i         (head_elem),
    .stat_i         (stat),
    .pop_o          (pop),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
`default_nettype wire

@@ rtl/normalized_magnitude_entropy_checker.sv @@
`default_nettype none
`include "normalized_magnitude_entropy_assert.svh"
module normalized_magnitude_entropy_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire nme_pkg::sample_t sample_i,
  input wire nme_pkg::result_t result_o,
  input wire logic             result_valid_o
);

  `NME_ASSERT_IMP(a_one_flag, clk_i, rst_ni, result_valid_o, !(result_o.zero_norm_error && result_o.length_error), "both error flags set")
  `NME_ASSERT_IMP(a_flag_zero, clk_i, rst_ni, result_valid_o && (result_o.zero_norm_error || result_o.length_error), result_o.entropy_value == '0, "flagged result with nonzero value")
  `NME_ASSERT_NXT(a_strobe_gap, clk_i, rst_ni, result_valid_o, !result_valid_o, "result strobe on consecutive cycles")

endmodule

bind normalized_magnitude_entropy normalized_magnitude_entropy_checker u_checker (.*);
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int WatchdogLimit = 50000;

  class entropy_scoreboard;
    logic [63:0]      sq_sum;
    logic [63:0]      mag_sum;
    logic [63:0]      maglog_sum;
    logic [63:0]      n_elems;
    nme_pkg::result_t psi_q[$];
    int               errors;

    function new();
      sq_sum = 0;
      mag_sum = 0;
      maglog_sum = 0;
      n_elems = 0;
      errors = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    // log2 in Q.24 by repeated squaring of a Q1.30 mantissa
    function logic [63:0] log2_fx(logic [63:0] x);
      int          msb;
      logic [63:0] m;
      logic [63:0] frac;
      msb = 63;
      frac = 0;
      if (x == 0) return 0;
      while (x[msb] == 1'b0) msb--;
      if (msb >= 30) m = x >> (msb - 30);
      else m = x << (30 - msb);
      for (int i = 0; i < nme_pkg::FracW; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac = frac | 64'd1;
        end
      end
      return (64'(msb) << 24) | frac;
    endfunction

    function logic [63:0] ln_fx(logic [63:0] x);
      return (log2_fx(x) * 64'(nme_pkg::Ln2Q32)) >> 32;
    endfunction

    function logic [63:0] abs_part(logic [15:0] f);
      logic [63:0] mask;
      logic [63:0] v;
      mask = (64'd1 << nme_pkg::PartW) - 1;
      v = 64'(f) & mask;
      if (v[nme_pkg::PartW-1]) return (mask + 1) - v;
      return v;
    endfunction

    function void note_request(nme_pkg::sample_t s);
      logic [63:0]      re_a, im_a, sq, mag, ln_s, s5, pos, num, psi;
      nme_pkg::result_t r;
      re_a = abs_part(s.sample_real);
      im_a = abs_part(s.sample_imag);
      if (n_elems < nme_pkg::MaxSamples) begin
        sq = re_a * re_a + im_a * im_a;
        mag = int_sqrt(sq);
        sq_sum += sq;
        if (mag != 0) begin
          mag_sum += mag;
          maglog_sum += mag * ln_fx(mag);
        end
      end
      if (n_elems <= nme_pkg::MaxSamples) n_elems++;
      if (!s.last_sample) return;
      r = '0;
      if (n_elems > nme_pkg::MaxSamples) begin
        r.length_error = 1'b1;
      end else if (sq_sum == 0) begin
        r.zero_norm_error = 1'b1;
      end else begin
        ln_s = ln_fx(sq_sum) >> 1;
        s5 = int_sqrt(sq_sum << 10);
        pos = ln_s * mag_sum;
        num = (pos > maglog_sum) ? pos - maglog_sum : 0;
        psi = (2 * num) / s5;
        if (psi > 64'hFF_FFFF) psi = 64'hFF_FFFF;
        r.entropy_value = psi[23:0];
      end
      psi_q.push_back(r);
      sq_sum = 0;
      mag_sum = 0;
      maglog_sum = 0;
      n_elems = 0;
    endfunction

    function void check_result(nme_pkg::result_t got);
      nme_pkg::result_t exp_r;
      if (psi_q.size() == 0) begin
        $error("unexpected result: entropy_value %0d", got.entropy_value);
        errors++;
        return;
      end
      exp_r = psi_q.pop_front();
      if (got.entropy_value !== exp_r.entropy_value) begin
        $error("entropy_value: expected %0d, actual %0d", exp_r.entropy_value,
               got.entropy_value);
        errors++;
      end
      if (got.zero_norm_error !== exp_r.zero_norm_error) begin
        $error("zero_norm_error: expected %0d, actual %0d", exp_r.zero_norm_error,
               got.zero_norm_error);
        errors++;
      end
      if (got.length_error !== exp_r.length_error) begin
        $error("length_error: expected %0d, actual %0d", exp_r.length_error,
               got.length_error);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  nme_pkg::sample_t sample_i;
  nme_pkg::result_t result_o;
  logic             result_valid_o;

  entropy_scoreboard sb;
  int                idle_cycles;
  bit                no_gaps;

  normalized_magnitude_entropy uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .sample_i      (sample_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
    if ((start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("** normalized_magnitude_entropy: FAILED **");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 60);
  endfunction

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      2: return 16'($signed($urandom_range(0, 30)) - 15);
      default: return 16'($urandom);
    endcase
  endfunction

  // drive one request and wait for it to be taken
  task automatic send(logic [15:0] re, logic [15:0] im, logic last, int gap);
    nme_pkg::sample_t s;
    s.sample_real = re;
    s.sample_imag = im;
    s.last_sample = last;
    start <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (busy);
    sb.note_request(s);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    int n_items;
    int len;
    sb = new();
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    sample_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single nonzero element: numerator clamp case
    send(16'h8000, 16'h8000, 1'b1, 1);
    send(16'h7FFF, 16'h0000, 1'b1, 0);
    // all-zero vector and single zero sample
    send(16'h0000, 16'h0000, 1'b0, 0);
    send(16'h0000, 16'h0000, 1'b0, 2);
    send(16'h0000, 16'h0000, 1'b1, 0);
    send(16'h0000, 16'h0000, 1'b1, 5);
    // extremes mixed with zeros
    send(16'h7FFF, 16'h8000, 1'b0, 0);
    send(16'h0000, 16'h0000, 1'b0, 0);
    send(16'h8000, 16'h7FFF, 1'b0, 0);
    send(16'hFFFF, 16'h0001, 1'b0, 3);
    send(16'h0001, 16'hFFFF, 1'b0, 0);
    send(16'h5555, 16'hAAAA, 1'b1, 0);
    // equal magnitudes, real vector
    for (int i = 0; i < 8; i++) send(16'h0100, 16'h0000, i == 7, 0);

    n_items = 0;
    while (n_items < 1030) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        send(pick_part(), pick_part(), i == len - 1, pick_gap());
        n_items++;
      end
    end
    start <= 1'b0;

    while (sb.psi_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.psi_q.size() == 0) begin
      $display("** normalized_magnitude_entropy: PASSED **");
    end else begin
      $display("** normalized_magnitude_entropy: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/nme_pkg.sv
rtl/nme_front.sv
rtl/nme_fifo.sv
rtl/nme_back.sv
rtl/normalized_magnitude_entropy.sv
rtl/normalized_magnitude_entropy_checker.sv
dv/tb.sv
